// ===== sv/mmrp_pkg.sv =====
// ----------------------------------------------------------------------------
// Modbus meter reply parser package
// Shared types, frame constants and the Modbus CRC-16 byte update.
// ----------------------------------------------------------------------------
package mmrp_pkg;

	// Parser phase: waiting for address, address seen, collecting frame body.
	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_ADDR = 2'd1,
		PH_BODY = 2'd2
	} phase_t;

	localparam logic [7:0]  MeterAddrReset = 8'h18;
	localparam logic [7:0]  FuncCode       = 8'h04;
	localparam logic [15:0] CrcInit        = 16'hFFFF;
	localparam logic [15:0] CrcPoly        = 16'hA001;
	localparam logic [6:0]  Scale          = 7'd100;

	// Byte positions inside the nine-byte reply frame.
	localparam logic [3:0] IdxFirstBody = 4'd2;
	localparam logic [3:0] IdxFloat0    = 4'd3;
	localparam logic [3:0] IdxFloat1    = 4'd4;
	localparam logic [3:0] IdxFloat2    = 4'd5;
	localparam logic [3:0] IdxFloat3    = 4'd6;
	localparam logic [3:0] IdxCrcLo     = 4'd7;
	localparam logic [3:0] IdxCrcHi     = 4'd8;
	localparam logic [3:0] FrameLen     = 4'd9;

	// Float exponent bounds for the times-100 conversion.
	localparam logic [7:0] ExpInfNan  = 8'hFF;
	localparam logic [7:0] ExpUnity   = 8'd150;
	localparam logic [7:0] ExpMinLive = 8'd119;
	localparam logic [7:0] ExpMaxLive = 8'd152;

	// One byte of the reflected Modbus CRC-16, eight bit steps.
	function automatic logic [15:0] crc_feed(input logic [15:0] crc_in, input logic [7:0] b);
		logic [15:0] c;
		c = crc_in ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CrcPoly;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

// ===== sv/modbus_meter_reply_parser_unit.sv =====
// ----------------------------------------------------------------------------
// Modbus meter reply parser
// Recognizes a nine-byte function 04 reply from one meter, checks its
// CRC-16 and reports the float reading times 100.
// ----------------------------------------------------------------------------
// Usage:
// Received serial bytes enter on rx_byte with in_valid; a transaction takes
// place on a clock edge where in_valid is high and in_stall is low. One
// byte is taken every cycle while in_stall is low. Each byte is parsed in
// the cycle it is taken: the CRC update, the byte store and the phase
// change all happen at that edge. The mantissa product is formed when the
// first CRC byte arrives and shifted into place when the second arrives.
// One result per complete frame appears on out_valid the cycle after the
// ninth byte is taken: status 0 with the value, or status 1 with zero
// words when the CRC does not match. Frames that are cut short by a wrong
// function byte produce nothing.
// The result register holds its transaction while out_stall is high. Bytes
// keep flowing while a result waits; only the ninth byte of the next frame
// is held off with in_stall until the waiting result is taken.
// Reset clears the parser to idle, empties the result register and sets
// the meter address to 0x18. cfg_wr_en writes a new meter address, which
// is used from the next frame start on.
// ----------------------------------------------------------------------------
module modbus_meter_reply_parser_unit
	import mmrp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [7:0]  cfg_wr_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        status,
	output logic [15:0] value_high,
	output logic [15:0] value_low
);

	phase_t      phase_q, phase_d;
	logic [3:0]  idx_q, idx_d;
	logic [15:0] crc_q, crc_d;
	logic [7:0]  meter_addr_q;
	logic [31:0] float_q;
	logic [7:0]  crc_lo_q;

	logic        out_valid_q;
	logic        status_q;
	logic [15:0] value_high_q;
	logic [15:0] value_low_q;

	logic        accept;
	logic        finishing;
	logic        emit;
	logic        scale_load;
	logic [15:0] crc_next;
	logic [31:0] scaled;

	// Only the byte that would complete a frame waits on the result register.
	assign finishing = (phase_q == PH_BODY) && (idx_q == IdxCrcHi);
	assign in_stall  = out_valid_q && out_stall && finishing;
	assign accept    = in_valid && !in_stall;

	// Running CRC: restarted on the address byte, otherwise continued.
	assign crc_next = crc_feed((phase_q == PH_ADDR || phase_q == PH_BODY) ? crc_q : CrcInit,
		rx_byte);

	// Parser next state.
	always_comb begin
		phase_d    = phase_q;
		idx_d      = idx_q;
		crc_d      = crc_q;
		emit       = 1'b0;
		scale_load = 1'b0;
		if (accept) begin
			case (phase_q)
				PH_ADDR: begin
					if (rx_byte == FuncCode) begin
						crc_d   = crc_next;
						idx_d   = IdxFirstBody;
						phase_d = PH_BODY;
					end else begin
						crc_d   = CrcInit;
						idx_d   = 4'd0;
						phase_d = PH_IDLE;
					end
				end
				PH_BODY: begin
					if (idx_q >= FrameLen || idx_q == IdxCrcHi) begin
						emit    = (idx_q == IdxCrcHi);
						crc_d   = CrcInit;
						idx_d   = 4'd0;
						phase_d = PH_IDLE;
					end else begin
						if (idx_q < IdxCrcLo) begin
							crc_d = crc_next;
						end
						scale_load = (idx_q == IdxCrcLo);
						idx_d      = idx_q + 4'd1;
					end
				end
				default: begin
					if (rx_byte == meter_addr_q) begin
						crc_d   = crc_next;
						idx_d   = 4'd1;
						phase_d = PH_ADDR;
					end else begin
						idx_d   = 4'd0;
						phase_d = PH_IDLE;
					end
				end
			endcase
		end
	end

	// Parser control state and configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			idx_q        <= 4'd0;
			crc_q        <= CrcInit;
			meter_addr_q <= MeterAddrReset;
		end else begin
			phase_q <= phase_d;
			idx_q   <= idx_d;
			crc_q   <= crc_d;
			if (cfg_wr_en) begin
				meter_addr_q <= cfg_wr_data;
			end
		end
	end

	// Frame byte store: the float bytes and the low CRC byte.
	always_ff @(posedge clk) begin
		if (accept && phase_q == PH_BODY) begin
			case (idx_q)
				IdxFloat0: float_q[31:24] <= rx_byte;
				IdxFloat1: float_q[23:16] <= rx_byte;
				IdxFloat2: float_q[15:8]  <= rx_byte;
				IdxFloat3: float_q[7:0]   <= rx_byte;
				IdxCrcLo:  crc_lo_q       <= rx_byte;
				default: begin
				end
			endcase
		end
	end

	// Conversion of the stored float, started on the low CRC byte.
	mmrp_scale u_scale (
		.clk   (clk),
		.load  (scale_load),
		.bits  (float_q),
		.value (scaled)
	);

	// Result register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload: check the received CRC against the running one.
	always_ff @(posedge clk) begin
		if (emit) begin
			if ({rx_byte, crc_lo_q} == crc_q) begin
				status_q     <= 1'b0;
				value_high_q <= scaled[31:16];
				value_low_q  <= scaled[15:0];
			end else begin
				status_q     <= 1'b1;
				value_high_q <= 16'd0;
				value_low_q  <= 16'd0;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign value_high = value_high_q;
	assign value_low  = value_low_q;

endmodule

// ===== sv/mmrp_scale.sv =====
// ----------------------------------------------------------------------------
// Float times 100 conversion
// Two-step conversion of an IEEE-754 single to an unsigned 32-bit value of
// the float times 100, truncated. The first step classifies the float and
// multiplies the mantissa; the second shifts and saturates.
// ----------------------------------------------------------------------------
module mmrp_scale
	import mmrp_pkg::*;
(
	input  logic        clk,
	input  logic        load,
	input  logic [31:0] bits,
	output logic [31:0] value
);

	logic        sign;
	logic [7:0]  expo;
	logic [22:0] mant;
	logic        is_zero;
	logic        is_sat;
	logic [30:0] prod;

	logic        zero_q;
	logic        sat_q;
	logic [7:0]  expo_q;
	logic [30:0] prod_q;

	logic [7:0]  ldiff;
	logic [7:0]  rdiff;
	logic [32:0] lsh;
	logic [31:0] rsh;

	// Classify the float and form the exact mantissa product.
	always_comb begin
		sign = bits[31];
		expo = bits[30:23];
		mant = bits[22:0];
		if (expo == ExpInfNan) begin
			is_zero = (mant != 23'd0) || sign;
			is_sat  = !sign && (mant == 23'd0);
		end else begin
			is_zero = sign || (expo < ExpMinLive);
			is_sat  = !sign && (expo > ExpMaxLive);
		end
		prod = 31'({1'b1, mant}) * 31'(Scale);
	end

	// Hold the classification and product until the frame is checked.
	always_ff @(posedge clk) begin
		if (load) begin
			zero_q <= is_zero;
			sat_q  <= is_sat;
			expo_q <= expo;
			prod_q <= prod;
		end
	end

	// Shift the product into place and saturate on overflow.
	always_comb begin
		ldiff = expo_q - ExpUnity;
		rdiff = ExpUnity - expo_q;
		lsh   = {2'b00, prod_q} << ldiff[1:0];
		rsh   = {1'b0, prod_q} >> rdiff[4:0];
		if (zero_q) begin
			value = 32'd0;
		end else if (sat_q) begin
			value = 32'hFFFF_FFFF;
		end else if (expo_q >= ExpUnity) begin
			value = lsh[32] ? 32'hFFFF_FFFF : lsh[31:0];
		end else begin
			value = rsh;
		end
	end

endmodule

// ===== sv/mmrp_chk.sv =====
// ----------------------------------------------------------------------------
// Modbus meter reply parser port checker
// Concurrent checks on the ports of the parser, bound to the top level.
// ----------------------------------------------------------------------------
module mmrp_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic        status,
	input logic [15:0] value_high,
	input logic [15:0] value_low
);

	// A stalled result stays valid.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	// A stalled result keeps its payload.
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(status) && $stable(value_high) && $stable(value_low))
		else $error("result payload changed while stalled");

	// A CRC failure carries zero value words.
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status |-> value_high == 16'd0 && value_low == 16'd0)
		else $error("CRC failure with nonzero value");

	// A new result follows an accepted byte.
	a_out_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && !in_stall))
		else $error("result without an accepted byte");

	// Input is held off only behind a stalled result.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled with no waiting result");

endmodule

bind modbus_meter_reply_parser_unit mmrp_chk u_mmrp_chk (.*);

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modbus meter reply parser testbench
// Streams received bytes into the parser and checks every reply result
// against a byte-level parser model kept in this bench. Sender gaps and
// receiver stalls are drawn per transaction, and the meter address is
// rewritten between stimulus segments while the parser is idle.
// ----------------------------------------------------------------------------
module testbench;
	import mmrp_pkg::*;

	localparam int  CycleLimit     = 400000;
	localparam int  DrainCycles    = 4;
	localparam int  LongHoldCycles = 300;
	localparam logic StatusGood     = 1'b0;
	localparam logic StatusCrcError = 1'b1;

	typedef struct {
		logic        status_bit;
		logic [15:0] word_high;
		logic [15:0] word_low;
	} reading_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_wr_en = 1'b0;
	logic [7:0]  cfg_wr_data = 8'h00;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  rx_byte = 8'h00;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        status;
	logic [15:0] value_high;
	logic [15:0] value_low;

	// Bytes waiting to be offered and readings the parser still owes.
	logic [7:0] byte_queue [$];
	reading_t   pending_readings [$];

	// Parser model state.
	phase_t      pr_phase = PH_IDLE;
	logic [3:0]  pr_index = 4'd0;
	logic [7:0]  pr_frame [0:8];
	logic [15:0] pr_crc = CrcInit;
	logic [7:0]  pr_addr = MeterAddrReset;

	// Handshake pacing.
	bit offering = 1'b0;
	bit quiet_mode = 1'b0;
	bit hold_request = 1'b0;
	bit long_hold_done = 1'b0;
	int gap_left = 0;
	int stall_left = 0;
	int hold_left = 0;

	// Run statistics.
	int error_count = 0;
	int bytes_pushed = 0;
	int bytes_taken = 0;
	int readings_checked = 0;
	int good_count = 0;
	int crc_error_count = 0;
	int cfg_writes = 0;
	int cycle_count = 0;

	modbus_meter_reply_parser_unit i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.rx_byte     (rx_byte),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.value_high  (value_high),
		.value_low   (value_low)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Modbus CRC-16, one data bit folded in per step.
	function automatic logic [15:0] crc_step(input logic [15:0] acc, input logic [7:0] data);
		logic [15:0] nxt;
		nxt = acc;
		for (int k = 0; k < 8; k++) begin
			nxt = (nxt >> 1) ^ ((nxt[0] ^ data[k]) ? CrcPoly : 16'h0000);
		end
		return nxt;
	endfunction

	// Exact float times 100, truncated, clamped to the unsigned 32-bit range.
	function automatic logic [31:0] scaled_reading(input logic [31:0] f);
		logic [7:0]  ex;
		logic [23:0] man;
		logic [63:0] prod;
		int          sh;
		ex  = f[30:23];
		man = {1'b0, f[22:0]};
		if (ex == ExpInfNan) begin
			return (f[22:0] != 23'd0 || f[31]) ? 32'd0 : 32'hFFFF_FFFF;
		end
		if (f[31]) begin
			return 32'd0;
		end
		if (ex == 8'd0) begin
			ex = 8'd1;
		end else begin
			man[23] = 1'b1;
		end
		if (man == 24'd0) begin
			return 32'd0;
		end
		prod = 64'(man) * 64'(Scale);
		sh = int'(ex) - int'(ExpUnity);
		if (sh >= 0) begin
			if (sh > 32) begin
				return 32'hFFFF_FFFF;
			end
			prod = prod << sh;
			if (prod[63:32] != 32'd0) begin
				return 32'hFFFF_FFFF;
			end
			return prod[31:0];
		end
		prod = prod >> (-sh);
		return prod[31:0];
	endfunction

	function automatic int draw_wait();
		return quiet_mode ? 0 : $urandom_range(0, 3);
	endfunction

	task automatic restart_parse();
		pr_phase = PH_IDLE;
		pr_index = 4'd0;
		pr_crc   = CrcInit;
	endtask

	// Advance the parser model by one accepted byte.
	task automatic track_byte(input logic [7:0] b);
		reading_t    r;
		logic [31:0] v;
		case (pr_phase)
			PH_ADDR: begin
				if (b == FuncCode) begin
					pr_frame[1] = b;
					pr_crc = crc_step(pr_crc, b);
					pr_index = IdxFirstBody;
					pr_phase = PH_BODY;
				end else begin
					restart_parse();
				end
			end
			PH_BODY: begin
				if (pr_index >= FrameLen) begin
					restart_parse();
				end else begin
					pr_frame[pr_index] = b;
					if (pr_index < IdxCrcLo) begin
						pr_crc = crc_step(pr_crc, b);
					end
					pr_index = pr_index + 4'd1;
					if (pr_index == FrameLen) begin
						if ({pr_frame[IdxCrcHi], pr_frame[IdxCrcLo]} == pr_crc) begin
							v = scaled_reading({pr_frame[IdxFloat0], pr_frame[IdxFloat1],
								pr_frame[IdxFloat2], pr_frame[IdxFloat3]});
							r.status_bit = StatusGood;
							r.word_high  = v[31:16];
							r.word_low   = v[15:0];
						end else begin
							r.status_bit = StatusCrcError;
							r.word_high  = 16'd0;
							r.word_low   = 16'd0;
						end
						pending_readings.push_back(r);
						restart_parse();
					end
				end
			end
			default: begin
				// Idle: only the meter address opens a frame.
				if (b == pr_addr) begin
					pr_crc = crc_step(CrcInit, b);
					pr_frame[0] = b;
					pr_index = 4'd1;
					pr_phase = PH_ADDR;
				end else begin
					pr_phase = PH_IDLE;
					pr_index = 4'd0;
				end
			end
		endcase
	endtask

	task automatic push_byte(input logic [7:0] b);
		byte_queue.push_back(b);
		bytes_pushed++;
	endtask

	// Queue one reply frame; a bad one gets a single flipped bit after the address pair.
	task automatic add_frame(input logic [7:0] addr_b, input logic [7:0] count_b,
		input logic [31:0] fbits, input bit corrupt);
		logic [7:0]  fb [0:8];
		logic [15:0] c;
		int          pos;
		fb[0] = addr_b;
		fb[1] = FuncCode;
		fb[2] = count_b;
		fb[3] = fbits[31:24];
		fb[4] = fbits[23:16];
		fb[5] = fbits[15:8];
		fb[6] = fbits[7:0];
		c = CrcInit;
		for (int k = 0; k < 7; k++) begin
			c = crc_step(c, fb[k]);
		end
		fb[7] = c[7:0];
		fb[8] = c[15:8];
		if (corrupt) begin
			pos = $urandom_range(2, 8);
			fb[pos] = fb[pos] ^ (8'h01 << $urandom_range(0, 7));
		end
		for (int k = 0; k < 9; k++) begin
			push_byte(fb[k]);
		end
	endtask

	// Float patterns: mostly readable magnitudes, some raw bits and edge values.
	function automatic logic [31:0] random_float();
		int          r;
		logic [31:0] f;
		r = $urandom_range(0, 99);
		if (r < 12) begin
			case ($urandom_range(0, 8))
				0: f = 32'h0000_0000;
				1: f = 32'h8000_0000;
				2: f = 32'h7F80_0000;
				3: f = 32'hFF80_0000;
				4: f = 32'h7FC0_0000;
				5: f = 32'h0000_0001;
				6: f = 32'h4F80_0000;
				7: f = 32'h4C23_D70A;
				default: f = 32'h3C23_D70A;
			endcase
		end else if (r < 27) begin
			f = $urandom;
		end else begin
			f = {($urandom_range(0, 15) == 0), 8'($urandom_range(112, 160)), 23'($urandom)};
		end
		return f;
	endfunction

	// One random unit of line traffic, mostly well-formed replies.
	task automatic add_random_unit();
		int         pick;
		logic [7:0] b;
		logic [7:0] cnt;
		pick = $urandom_range(0, 99);
		cnt = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'h04;
		if (pick < 60) begin
			add_frame(pr_addr, cnt, random_float(), 1'b0);
		end else if (pick < 70) begin
			add_frame(pr_addr, cnt, random_float(), 1'b1);
		end else if (pick < 78) begin
			b = 8'($urandom);
			if (b == FuncCode) begin
				b = b ^ 8'h01;
			end
			push_byte(pr_addr);
			push_byte(b);
		end else if (pick < 83) begin
			push_byte(pr_addr);
			push_byte(FuncCode);
			repeat ($urandom_range(0, 5)) push_byte(8'($urandom));
		end else if (pick < 93) begin
			repeat ($urandom_range(1, 4)) push_byte(8'($urandom));
		end else begin
			add_frame(pr_addr ^ 8'($urandom_range(1, 255)), cnt, random_float(),
				bit'($urandom_range(0, 1)));
		end
	endtask

	// Random traffic, closed by filler bytes that always bring the parser back to idle.
	task automatic fill_random(input int target);
		int start;
		start = bytes_pushed;
		while (bytes_pushed - start < target) begin
			add_random_unit();
		end
		repeat (9) push_byte(~pr_addr);
	endtask

	// Wait until every byte is taken and every reading has arrived.
	task automatic wait_drained();
		do begin
			@(negedge clk);
		end while (byte_queue.size() != 0 || offering || pending_readings.size() != 0);
		repeat (DrainCycles) @(negedge clk);
	endtask

	task automatic write_meter_address(input logic [7:0] v);
		@(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		pr_addr = v;
		cfg_writes++;
		@(negedge clk);
	endtask

	// Byte driver: one transaction at a time, held while the parser stalls.
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				track_byte(rx_byte);
				bytes_taken++;
				offering = 1'b0;
				gap_left = draw_wait();
			end
			if (!offering) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (byte_queue.size() != 0) begin
					rx_byte  <= byte_queue.pop_front();
					in_valid <= 1'b1;
					offering = 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Reading monitor: compares each result transaction and paces out_stall.
	always @(posedge clk) begin
		reading_t exp_r;
		bit       took;
		if (arst_n) begin
			took = out_valid && !out_stall;
			if (took) begin
				readings_checked++;
				if (status == StatusGood) begin
					good_count++;
				end else begin
					crc_error_count++;
				end
				if (pending_readings.size() == 0) begin
					$display("%0t: unexpected reading status %0d high %h low %h",
						$time, status, value_high, value_low);
					error_count++;
				end else begin
					exp_r = pending_readings.pop_front();
					if (status !== exp_r.status_bit) begin
						$display("%0t: status expected %0d, got %0d",
							$time, exp_r.status_bit, status);
						error_count++;
					end
					if (value_high !== exp_r.word_high) begin
						$display("%0t: value_high expected %h, got %h",
							$time, exp_r.word_high, value_high);
						error_count++;
					end
					if (value_low !== exp_r.word_low) begin
						$display("%0t: value_low expected %h, got %h",
							$time, exp_r.word_low, value_low);
						error_count++;
					end
				end
				stall_left = draw_wait();
			end else if (out_valid && out_stall && stall_left > 0) begin
				stall_left--;
			end
			// A single long hold-off lets the parser back up into its input.
			if (hold_request && !long_hold_done) begin
				hold_left = LongHoldCycles;
				long_hold_done = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= (stall_left > 0);
			end
		end
	end

	// Watchdog on the whole run.
	initial begin
		while (cycle_count < CycleLimit) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Test completed with failures");
		$finish;
	end

	// Stimulus sequence.
	initial begin
		logic [7:0] next_addr;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: idle noise at both byte extremes, a wrong function byte,
		// a good reply whose count byte equals the address, a corrupted reply.
		push_byte(8'h00);
		push_byte(8'hFF);
		push_byte(MeterAddrReset);
		push_byte(8'h03);
		add_frame(MeterAddrReset, MeterAddrReset, 32'h42C8_0000, 1'b0);
		add_frame(MeterAddrReset, FuncCode, 32'h7F80_0000, 1'b1);
		wait_drained();

		// Random segments, each under its own meter address.
		for (int seg = 0; seg < 5; seg++) begin
			case (seg)
				0: next_addr = 8'h00;
				1: next_addr = 8'hFF;
				2: next_addr = FuncCode;
				3: next_addr = 8'($urandom);
				default: next_addr = MeterAddrReset;
			endcase
			write_meter_address(next_addr);
			quiet_mode = (seg == 1);
			if (seg == 2) begin
				// Sender stops halfway until the parser has caught up.
				fill_random(110);
				wait_drained();
				fill_random(110);
			end else begin
				fill_random(220);
				if (seg == 3) begin
					hold_request = 1'b1;
				end
			end
			wait_drained();
		end

		$display("Sent %0d bytes under %0d meter address writes; %0d readings checked.",
			bytes_taken, cfg_writes, readings_checked);
		$display("Good frames %0d, CRC-rejected frames %0d, mismatches %0d.",
			good_count, crc_error_count, error_count);
		if (error_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
